[rtl/pfat_pkg.sv]
package pfat_pkg;

  // Memory geometry.
  localparam int FRAME_BYTES = 16;
  localparam int NUM_FRAMES  = 32;
  localparam int NUM_PROCS   = 8;

  // Derived widths.
  localparam int OFF_W   = $clog2(FRAME_BYTES);
  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int PID_W   = $clog2(NUM_PROCS);
  localparam int RAM_AW  = FRAME_W + OFF_W;
  localparam int PT_AW   = PID_W + FRAME_W;
  localparam int CNT_W   = FRAME_W + 1;

  // Request field widths.
  localparam int REQ_W  = 2;
  localparam int VA_W   = 9;
  localparam int LEN_W  = 10;
  localparam int DATA_W = 8;
  localparam int STS_W  = 2;
  localparam int NEED_W = LEN_W + 1 - OFF_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_WRITE   = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_BADPAGE = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_clr;
    logic capture;
    logic start;
    logic xlate;
    logic alloc_step;
    logic rel_rd;
    logic rel_clr;
    logic resp_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req;
    logic alloc_fail;
    logic page_ok;
    logic rel_empty;
    logic alloc_done;
    logic clr_last;
    logic rel_last;
    logic init_last;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/pfat_ctrl.sv]
module pfat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  pfat_pkg::dp_sts_t sts,
  output pfat_pkg::dp_cmd_t cmd
);
  import pfat_pkg::*;

  typedef enum logic [7:0] {
    S_INIT    = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_START   = 8'b0000_0100,
    S_XLATE   = 8'b0000_1000,
    S_ALLOC   = 8'b0001_0000,
    S_REL_RD  = 8'b0010_0000,
    S_REL_CLR = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_clr = 1'b1;
        if (sts.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        unique case (sts.req)
          REQ_ALLOC:   state_nxt = sts.alloc_fail ? S_RESP : S_ALLOC;
          REQ_READ:    state_nxt = sts.page_ok ? S_XLATE : S_RESP;
          REQ_WRITE:   state_nxt = sts.page_ok ? S_XLATE : S_RESP;
          REQ_RELEASE: state_nxt = sts.rel_empty ? S_RESP : S_REL_RD;
          default:     state_nxt = S_RESP;
        endcase
      end
      S_XLATE: begin
        cmd.xlate = 1'b1;
        state_nxt = S_RESP;
      end
      S_ALLOC: begin
        cmd.alloc_step = 1'b1;
        if (sts.alloc_done) begin
          state_nxt = S_RESP;
        end
      end
      S_REL_RD: begin
        cmd.rel_rd = 1'b1;
        state_nxt  = S_REL_CLR;
      end
      S_REL_CLR: begin
        cmd.rel_clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = sts.rel_last ? S_RESP : S_REL_RD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/pfat_dp.sv]
module pfat_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfat_pkg::dp_cmd_t            cmd,
  output pfat_pkg::dp_sts_t            sts,
  input  logic [pfat_pkg::REQ_W-1:0]   req_type,
  input  logic [pfat_pkg::PID_W-1:0]   process_id,
  input  logic [pfat_pkg::VA_W-1:0]    vaddr,
  input  logic [pfat_pkg::LEN_W-1:0]   alloc_length,
  input  logic [pfat_pkg::DATA_W-1:0]  write_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [pfat_pkg::DATA_W-1:0]  read_data,
  output logic [pfat_pkg::STS_W-1:0]   status,
  output logic [pfat_pkg::CNT_W-1:0]   page_total
);
  import pfat_pkg::*;

  // Captured request.
  req_t                req_r;
  logic [PID_W-1:0]    pid_r;
  logic [VA_W-1:0]     vaddr_r;
  logic [LEN_W-1:0]    len_r;
  logic [DATA_W-1:0]   wdata_r;

  // Working counters.
  logic [NEED_W-1:0]   need_r;
  logic [FRAME_W-1:0]  scan_r;
  logic [FRAME_W-1:0]  rel_idx_r;
  logic [OFF_W-1:0]    byte_r;
  logic [RAM_AW-1:0]   init_r;
  status_t             status_r;

  // Allocation state.
  logic [CNT_W-1:0]    free_cnt_r;
  logic                frame_used_r [NUM_FRAMES];
  logic [CNT_W-1:0]    page_cnt_r [NUM_PROCS];

  // Page table and frame RAM.
  logic [FRAME_W-1:0]  pt_mem [1 << PT_AW];
  logic [FRAME_W-1:0]  pt_q;
  logic [DATA_W-1:0]   ram_mem [1 << RAM_AW];
  logic [DATA_W-1:0]   ram_q;

  // Result register.
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_data_r;
  status_t             out_status_r;
  logic [CNT_W-1:0]    out_total_r;

  logic [LEN_W:0]      need_sum;
  logic [NEED_W-1:0]   need;
  logic [CNT_W-1:0]    cnt_cur;
  logic [FRAME_W-1:0]  page;
  logic                alloc_hit;
  logic                clr_last;
  logic                rel_last;
  logic [PT_AW-1:0]    pt_raddr;
  logic                ram_we;
  logic [RAM_AW-1:0]   ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [RAM_AW-1:0]   xlate_addr;

  // Frames needed: length rounded up to whole frames.
  assign need_sum  = {1'b0, len_r} + (LEN_W+1)'(FRAME_BYTES - 1);
  assign need      = need_sum[LEN_W:OFF_W];
  assign cnt_cur   = page_cnt_r[pid_r];
  assign page      = vaddr_r[VA_W-1:OFF_W];
  assign alloc_hit = !frame_used_r[scan_r];
  assign clr_last  = (byte_r == {OFF_W{1'b1}});
  assign rel_last  = ((CNT_W'(rel_idx_r) + CNT_W'(1)) == cnt_cur);

  // Status toward the controller.
  always_comb begin
    sts            = '0;
    sts.req        = req_r;
    sts.alloc_fail = (len_r == '0) || (need > NEED_W'(free_cnt_r));
    sts.page_ok    = (CNT_W'(page) < cnt_cur);
    sts.rel_empty  = (cnt_cur == '0);
    sts.alloc_done = alloc_hit && (need_r == NEED_W'(1));
    sts.clr_last   = clr_last;
    sts.rel_last   = rel_last;
    sts.init_last  = (init_r == {RAM_AW{1'b1}});
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= req_t'(req_type);
      pid_r   <= process_id;
      vaddr_r <= vaddr;
      len_r   <= alloc_length;
      wdata_r <= write_data;
    end
  end

  // Outcome decided when the request starts.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      priority if (req_r == REQ_ALLOC && sts.alloc_fail) begin
        status_r <= ST_NOFREE;
      end else if ((req_r == REQ_READ || req_r == REQ_WRITE) && !sts.page_ok) begin
        status_r <= ST_BADPAGE;
      end else begin
        status_r <= ST_OK;
      end
    end
  end

  // Scan, page and byte counters.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      need_r    <= need;
      scan_r    <= '0;
      rel_idx_r <= '0;
    end else begin
      if (cmd.alloc_step) begin
        scan_r <= scan_r + FRAME_W'(1);
        if (alloc_hit) begin
          need_r <= need_r - NEED_W'(1);
        end
      end
      if (cmd.rel_clr && clr_last) begin
        rel_idx_r <= rel_idx_r + FRAME_W'(1);
      end
    end
    if (cmd.rel_rd) begin
      byte_r <= '0;
    end else if (cmd.rel_clr) begin
      byte_r <= byte_r + OFF_W'(1);
    end
  end

  // Clearing sweep address after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
    end else if (cmd.init_clr) begin
      init_r <= init_r + RAM_AW'(1);
    end
  end

  // Frame bitmap, free count and page counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r <= CNT_W'(NUM_FRAMES);
      for (int f = 0; f < NUM_FRAMES; f++) begin
        frame_used_r[f] <= 1'b0;
      end
      for (int p = 0; p < NUM_PROCS; p++) begin
        page_cnt_r[p] <= '0;
      end
    end else begin
      if (cmd.alloc_step && alloc_hit) begin
        frame_used_r[scan_r] <= 1'b1;
        page_cnt_r[pid_r]    <= cnt_cur + CNT_W'(1);
        free_cnt_r           <= free_cnt_r - CNT_W'(1);
      end
      if (cmd.rel_clr && clr_last) begin
        frame_used_r[pt_q] <= 1'b0;
        free_cnt_r         <= free_cnt_r + CNT_W'(1);
        if (rel_last) begin
          page_cnt_r[pid_r] <= '0;
        end
      end
    end
  end

  // Page table: appended on allocate, read for translation and release.
  assign pt_raddr = cmd.rel_rd ? {pid_r, rel_idx_r} : {pid_r, page};

  always_ff @(posedge clk) begin
    if (cmd.alloc_step && alloc_hit) begin
      pt_mem[{pid_r, cnt_cur[FRAME_W-1:0]}] <= scan_r;
    end
    if (cmd.start || cmd.rel_rd) begin
      pt_q <= pt_mem[pt_raddr];
    end
  end

  // Frame RAM write selection: clearing sweep, byte write, release zeroing.
  assign xlate_addr = {pt_q, vaddr_r[OFF_W-1:0]};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = xlate_addr;
    ram_wdata = '0;
    if (cmd.init_clr) begin
      ram_we    = 1'b1;
      ram_waddr = init_r;
    end else if (cmd.rel_clr) begin
      ram_we    = 1'b1;
      ram_waddr = {pt_q, byte_r};
    end else if (cmd.xlate && req_r == REQ_WRITE) begin
      ram_we    = 1'b1;
      ram_wdata = wdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= ram_wdata;
    end
    if (cmd.xlate && req_r == REQ_READ) begin
      ram_q <= ram_mem[xlate_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_data_r   <= (req_r == REQ_READ && status_r == ST_OK) ? ram_q : '0;
      out_status_r <= status_r;
      out_total_r  <= cnt_cur;
    end
  end

  assign out_valid  = out_valid_r;
  assign read_data  = out_data_r;
  assign status     = out_status_r;
  assign page_total = out_total_r;

endmodule

[rtl/paged_frame_allocator_translator_top.sv]
// Channel | Direction | Handshake               | Payload
// in_     | request   | in_tvalid / in_tready   | in_tuser, in_tdata
// out_    | result    | out_tvalid / out_tready | out_tuser, out_tdata
//
// After reset the frame RAM is cleared one byte a cycle, all 512 bytes, in_tready low.
// A read or write goes from acceptance through a registered page-table read and a
// registered RAM access to the result load. Allocate scans the frame bitmap from frame 0
// up to the last frame it takes (frame 31 at most). Release reads the table and zeroes 16
// bytes per page held; a failure goes from the start state straight to the result load.
// One request is in work at a time; a held result stalls only the final result load.
module paged_frame_allocator_translator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // process_id[2:0], vaddr[11:3], alloc_length[21:12],
                                  // write_data[29:22], zero fill
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_data[7:0], page_total[13:8], zero fill
  output logic [1:0]  out_tuser   // status[1:0]
);
  import pfat_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [DATA_W-1:0]  read_data;
  logic [STS_W-1:0]   status;
  logic [CNT_W-1:0]   page_total;

  // Sequencing.
  pfat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Tables, RAM and result register.
  pfat_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (in_tuser),
    .process_id   (in_tdata[2:0]),
    .vaddr        (in_tdata[11:3]),
    .alloc_length (in_tdata[21:12]),
    .write_data   (in_tdata[29:22]),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .read_data    (read_data),
    .status       (status),
    .page_total   (page_total)
  );

  assign out_tdata = {2'b00, page_total, read_data};
  assign out_tuser = status;

`ifndef ASSERT_OFF
  // Only one request is in work: a new one is never taken right after acceptance.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in work");

  // A failed read or write returns no data.
  a_bad_page_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_BADPAGE) |-> (out_tdata[7:0] == 8'd0))
    else $error("bad page result carries data");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_NOFREE ||
                    out_tuser == ST_BADPAGE))
    else $error("undefined status code");

  // A process never holds more pages than there are frames.
  a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[13:8] <= 6'(NUM_FRAMES)))
    else $error("page count exceeds frame count");
`endif

endmodule
